// ===== hdl/itct_pkg.sv =====
// itct_pkg: shared types and constants for the in-flight timestamp commit tracker
// no dependencies; used by itct_ram users and inflight_timestamp_commit_tracker

package itct_pkg;

	// table geometry
	localparam int SLOTS = 16;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int TS_W = 64;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	// operation codes on the mode field
	typedef enum logic [1:0] {
		MODE_START   = 2'd0,
		MODE_COMMIT  = 2'd1,
		MODE_QRY_ONE = 2'd2,
		MODE_QRY_ALL = 2'd3
	} mode_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DUP    = 2'd1,
		ST_FULL   = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_APPLY,
		S_MIN,
		S_DONE
	} state_t;

endpackage

// ===== hdl/itct_ram.sv =====
// itct_ram: generic simple dual-port RAM, one write port, one registered read port
// no dependencies

module itct_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/inflight_timestamp_commit_tracker.sv =====
// inflight_timestamp_commit_tracker: top level, sequencer, watermarks and slot table
// depends on itct_pkg and itct_ram

// Tracks up to SLOTS (16) in-flight transaction timestamps plus a low and a
// high commit watermark. One transaction is worked on at a time; in_stall is
// high from acceptance until the sequencer is back in idle. Stamps live in a
// 16-entry RAM with a registered read, and one 64-bit comparator is walked over
// it one slot per cycle. A start, a commit or an is-committed query takes one
// lookup sweep. A commit of the oldest transaction that leaves others in flight
// adds a minimum sweep. The all-committed query needs no sweep. The result is
// held in an output register, so a new transaction is accepted while the
// previous result waits.

module inflight_timestamp_commit_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] ts,
	input  logic [63:0] clock_now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        committed_flag,
	output logic [63:0] low_mark,
	output logic [63:0] high_mark,
	output logic [4:0]  in_flight_count
);

	itct_pkg::state_t state_q, state_d;

	// control registers
	logic                           issue_q;
	logic                           rd_s1;
	logic [itct_pkg::IDX_W-1:0]     idx_q;
	logic [itct_pkg::IDX_W-1:0]     idx_s1;
	logic [itct_pkg::SLOTS-1:0]     valid_q;
	logic [itct_pkg::CNT_W-1:0]     count_q;
	logic [itct_pkg::TS_W-1:0]      low_q;
	logic [itct_pkg::TS_W-1:0]      high_q;
	logic                           out_valid_q;

	// transaction registers
	itct_pkg::mode_t                mode_q;
	logic [itct_pkg::TS_W-1:0]      ts_q;
	logic                           hit_q;
	logic [itct_pkg::IDX_W-1:0]     hit_idx_q;
	logic                           free_found_q;
	logic [itct_pkg::IDX_W-1:0]     free_idx_q;
	logic [itct_pkg::TS_W-1:0]      min_q;
	itct_pkg::status_t              status_q;
	logic                           flag_q;

	// output registers
	logic [1:0]                     out_status_q;
	logic                           out_flag_q;
	logic [itct_pkg::TS_W-1:0]      out_low_q;
	logic [itct_pkg::TS_W-1:0]      out_high_q;
	logic [4:0]                     out_count_q;

	// control strobes
	logic                           in_acc;
	logic                           scan_done;
	logic                           scan_start;
	logic                           out_load;
	logic                           need_min;
	logic                           ram_we;

	// shared comparator
	logic [itct_pkg::TS_W-1:0]      rd_data;
	logic [itct_pkg::TS_W-1:0]      cmp_b;
	logic                           cmp_eq;
	logic                           cmp_lt;

	// stamp table
	itct_ram #(
		.WIDTH(itct_pkg::TS_W),
		.DEPTH(itct_pkg::SLOTS)
	) u_stamp_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_idx_q),
		.wdata(ts_q),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	assign cmp_b  = (state_q == itct_pkg::S_MIN) ? min_q : ts_q;
	assign cmp_eq = (rd_data == cmp_b);
	assign cmp_lt = (rd_data < cmp_b);

	assign in_stall  = (state_q != itct_pkg::S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign scan_done = !issue_q && !rd_s1;
	assign need_min  = (mode_q == itct_pkg::MODE_COMMIT) && hit_q && (ts_q == low_q)
		&& (count_q != itct_pkg::CNT_W'(1));
	assign ram_we    = (state_q == itct_pkg::S_APPLY) && (mode_q == itct_pkg::MODE_START)
		&& !hit_q && free_found_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itct_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d    = state_q;
		scan_start = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			itct_pkg::S_IDLE: begin
				if (in_valid) begin
					if (itct_pkg::mode_t'(mode) == itct_pkg::MODE_QRY_ALL) begin
						state_d = itct_pkg::S_DONE;
					end else begin
						state_d    = itct_pkg::S_FIND;
						scan_start = 1'b1;
					end
				end
			end
			itct_pkg::S_FIND: begin
				if (scan_done) begin
					state_d = itct_pkg::S_APPLY;
				end
			end
			itct_pkg::S_APPLY: begin
				if (need_min) begin
					state_d    = itct_pkg::S_MIN;
					scan_start = 1'b1;
				end else begin
					state_d = itct_pkg::S_DONE;
				end
			end
			itct_pkg::S_MIN: begin
				if (scan_done) begin
					state_d = itct_pkg::S_DONE;
				end
			end
			itct_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = itct_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = itct_pkg::S_IDLE;
			end
		endcase
	end

	// scan pointer, table state and watermarks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q     <= 1'b0;
			rd_s1       <= 1'b0;
			idx_q       <= '0;
			idx_s1      <= '0;
			valid_q     <= '0;
			count_q     <= '0;
			low_q       <= itct_pkg::TS_W'(1);
			high_q      <= itct_pkg::TS_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			// sweep the ram one slot a cycle
			rd_s1  <= issue_q;
			idx_s1 <= idx_q;
			if (scan_start) begin
				issue_q <= 1'b1;
				idx_q   <= '0;
			end else if (issue_q) begin
				if (idx_q == itct_pkg::LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					idx_q <= idx_q + itct_pkg::IDX_W'(1);
				end
			end

			// apply start or commit
			if (state_q == itct_pkg::S_APPLY) begin
				case (mode_q)
					itct_pkg::MODE_START: begin
						if (hit_q || free_found_q) begin
							high_q <= ts_q + itct_pkg::TS_W'(1);
							if (count_q == '0) begin
								low_q <= ts_q;
							end
							if (!hit_q) begin
								valid_q[free_idx_q] <= 1'b1;
								count_q             <= count_q + itct_pkg::CNT_W'(1);
							end
						end
					end
					itct_pkg::MODE_COMMIT: begin
						if (hit_q) begin
							valid_q[hit_idx_q] <= 1'b0;
							count_q            <= count_q - itct_pkg::CNT_W'(1);
							if (ts_q == low_q && count_q == itct_pkg::CNT_W'(1)) begin
								low_q <= high_q;
							end
						end
					end
					default: begin
					end
				endcase
			end

			// new low watermark after the minimum sweep
			if (state_q == itct_pkg::S_MIN && scan_done) begin
				low_q <= min_q;
			end

			// output handshake
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// transaction payload and sweep results
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q       <= itct_pkg::mode_t'(mode);
			ts_q         <= ts;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			min_q        <= '1;
			status_q     <= itct_pkg::ST_OK;
			if (count_q == '0) begin
				flag_q <= (ts <= clock_now);
			end else begin
				flag_q <= (ts < low_q);
			end
		end

		// lookup sweep: matching slot and first free slot
		if (state_q == itct_pkg::S_FIND && rd_s1) begin
			if (valid_q[idx_s1] && cmp_eq) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
			end
			if (!valid_q[idx_s1] && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
		end

		// minimum sweep over remaining slots
		if (state_q == itct_pkg::S_MIN && rd_s1) begin
			if (valid_q[idx_s1] && cmp_lt) begin
				min_q <= rd_data;
			end
		end

		// status and query answer
		if (state_q == itct_pkg::S_APPLY) begin
			case (mode_q)
				itct_pkg::MODE_START: begin
					flag_q <= 1'b0;
					if (hit_q) begin
						status_q <= itct_pkg::ST_DUP;
					end else if (!free_found_q) begin
						status_q <= itct_pkg::ST_FULL;
					end
				end
				itct_pkg::MODE_COMMIT: begin
					flag_q <= 1'b0;
					if (!hit_q) begin
						status_q <= itct_pkg::ST_ABSENT;
					end
				end
				itct_pkg::MODE_QRY_ONE: begin
					if (ts_q < low_q) begin
						flag_q <= 1'b1;
					end else if (ts_q >= high_q) begin
						flag_q <= 1'b0;
					end else begin
						flag_q <= !hit_q;
					end
				end
				default: begin
				end
			endcase
		end

		// result register
		if (out_load) begin
			out_status_q <= status_q;
			out_flag_q   <= flag_q;
			out_low_q    <= low_q;
			out_high_q   <= high_q;
			out_count_q  <= 5'(count_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign committed_flag  = out_flag_q;
	assign low_mark        = out_low_q;
	assign high_mark       = out_high_q;
	assign in_flight_count = out_count_q;

	// live count tracks the valid bits
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("live count differs from number of valid slots");

	// a stamp is only written into a free slot
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !valid_q[free_idx_q])
		else $error("stamp written over an occupied slot");

	// no sweep is running while the block takes transactions
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itct_pkg::S_IDLE) |-> (!issue_q && !rd_s1))
		else $error("sweep active in idle");

	// a result is loaded only when the output register is free or draining
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overrun");

endmodule

// ===== bench/itct_commit_checker.sv =====
// itct_commit_checker: watches both channels of the commit tracker, predicts every reply
// and compares it field by field with what the block returns; depends on itct_pkg

module itct_commit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] ts,
	input  logic [63:0] clock_now,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic        committed_flag,
	input  logic [63:0] low_mark,
	input  logic [63:0] high_mark,
	input  logic [4:0]  in_flight_count,
	output int          fail_count,
	output int          waiting
);

	typedef struct packed {
		itct_pkg::status_t status;
		logic              flag;
		logic [63:0]       low;
		logic [63:0]       high;
		logic [4:0]        count;
	} reply_t;

	// shadow of the slot table and both watermarks
	bit          live [itct_pkg::SLOTS];
	logic [63:0] stamp [itct_pkg::SLOTS];
	logic [63:0] low_wm;
	logic [63:0] high_wm;
	int          live_n;
	reply_t      due_replies [$];
	int          mismatches;

	function automatic int slot_of(logic [63:0] t);
		for (int i = 0; i < itct_pkg::SLOTS; i++)
			if (live[i] && stamp[i] == t)
				return i;
		return -1;
	endfunction

	function automatic logic [63:0] oldest_stamp();
		logic [63:0] m;
		m = '1;
		for (int i = 0; i < itct_pkg::SLOTS; i++)
			if (live[i] && stamp[i] < m)
				m = stamp[i];
		return m;
	endfunction

	// applies one transaction to the shadow state and returns the reply it earns
	function automatic reply_t advance_tracker(itct_pkg::mode_t op, logic [63:0] t,
		logic [63:0] now);
		reply_t r;
		int     hit;
		int     spot;
		r.status = itct_pkg::ST_OK;
		r.flag = 1'b0;
		case (op)
			itct_pkg::MODE_START: begin
				hit = slot_of(t);
				spot = -1;
				for (int i = itct_pkg::SLOTS - 1; i >= 0; i--)
					if (!live[i])
						spot = i;
				if (hit < 0 && spot < 0) begin
					r.status = itct_pkg::ST_FULL;
				end else begin
					high_wm = t + 64'd1;
					if (live_n == 0)
						low_wm = t;
					if (hit >= 0) begin
						r.status = itct_pkg::ST_DUP;
					end else begin
						live[spot] = 1'b1;
						stamp[spot] = t;
						live_n++;
					end
				end
			end
			itct_pkg::MODE_COMMIT: begin
				hit = slot_of(t);
				if (hit < 0) begin
					r.status = itct_pkg::ST_ABSENT;
				end else begin
					live[hit] = 1'b0;
					live_n--;
					if (t == low_wm)
						low_wm = (live_n != 0) ? oldest_stamp() : high_wm;
				end
			end
			itct_pkg::MODE_QRY_ONE: begin
				if (t < low_wm)
					r.flag = 1'b1;
				else if (t >= high_wm)
					r.flag = 1'b0;
				else
					r.flag = (slot_of(t) < 0);
			end
			default: begin
				if (live_n == 0)
					r.flag = (t <= now);
				else
					r.flag = (t < low_wm);
			end
		endcase
		r.low = low_wm;
		r.high = high_wm;
		r.count = 5'(live_n);
		return r;
	endfunction

	// compare accepted replies first, then queue the reply of an accepted transaction
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < itct_pkg::SLOTS; i++)
				live[i] = 1'b0;
			low_wm = 64'd1;
			high_wm = 64'd1;
			live_n = 0;
			due_replies.delete();
			waiting <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reply with nothing outstanding: st %0d flag %0b low %h high %h cnt %0d",
							status, committed_flag, low_mark, high_mark, in_flight_count);
				end else begin
					want = due_replies.pop_front();
					if (status !== want.status || committed_flag !== want.flag ||
							low_mark !== want.low || high_mark !== want.high ||
							in_flight_count !== want.count) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("reply mismatch: want st %0d flag %0b low %h high %h cnt %0d",
								want.status, want.flag, want.low, want.high, want.count);
							$display("                got  st %0d flag %0b low %h high %h cnt %0d",
								status, committed_flag, low_mark, high_mark, in_flight_count);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				due_replies = {due_replies,
					advance_tracker(itct_pkg::mode_t'(mode), ts, clock_now)};
			waiting <= due_replies.size();
		end
		fail_count <= mismatches;
	end

endmodule

// ===== bench/inflight_timestamp_commit_tracker_test.sv =====
// inflight_timestamp_commit_tracker_test: stimulus and verdict for the commit tracker
// depends on itct_pkg, inflight_timestamp_commit_tracker and itct_commit_checker

module inflight_timestamp_commit_tracker_test;

	localparam int RANDOM_ITEMS = 1850;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [63:0] TS_MAX = '1;

	logic        clk;
	logic        arst_n;
	bit          in_valid;
	logic        in_stall;
	bit   [1:0]  mode;
	bit   [63:0] ts;
	bit   [63:0] clock_now;
	logic        out_valid;
	bit          out_stall;
	logic [1:0]  status;
	logic        committed_flag;
	logic [63:0] low_mark;
	logic [63:0] high_mark;
	logic [4:0]  in_flight_count;
	int          fail_count;
	int          waiting;

	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_req;
	bit          hold_taken;
	int          hold_left;
	logic [63:0] open_stamps [$];
	logic [63:0] wall;

	inflight_timestamp_commit_tracker DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .ts(ts), .clock_now(clock_now),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .committed_flag(committed_flag),
		.low_mark(low_mark), .high_mark(high_mark), .in_flight_count(in_flight_count)
	);

	itct_commit_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .ts(ts), .clock_now(clock_now),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .committed_flag(committed_flag),
		.low_mark(low_mark), .high_mark(high_mark), .in_flight_count(in_flight_count),
		.fail_count(fail_count), .waiting(waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off when requested
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// stimulus-side bookkeeping of what is in flight, used to pick sensible stamps
	function automatic int open_index(logic [63:0] t);
		for (int i = 0; i < open_stamps.size(); i++)
			if (open_stamps[i] == t)
				return i;
		return -1;
	endfunction

	function automatic int oldest_open();
		int k;
		k = 0;
		for (int i = 1; i < open_stamps.size(); i++)
			if (open_stamps[i] < open_stamps[k])
				k = i;
		return k;
	endfunction

	// offers one transaction and returns at the edge where it is taken
	task automatic send_op(input itct_pkg::mode_t op, input logic [63:0] t,
		input logic [63:0] now);
		int idx;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		ts <= t;
		clock_now <= now;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		idx = open_index(t);
		if (op == itct_pkg::MODE_START && idx < 0 && open_stamps.size() < itct_pkg::SLOTS)
			open_stamps = {open_stamps, t};
		if (op == itct_pkg::MODE_COMMIT && idx >= 0)
			open_stamps.delete(idx);
	endtask

	// mostly well-formed start/commit and query traffic on a moving clock, with some noise
	task automatic random_op();
		int          pick;
		int          k;
		logic [63:0] t;
		logic [63:0] now;
		if (open_stamps.size() == 0 && $urandom_range(15) == 0)
			wall = {$urandom, $urandom};
		pick = $urandom_range(99);
		now = wall + $urandom_range(0, 3);
		if (pick < 5) begin
			send_op(itct_pkg::mode_t'($urandom_range(3)), {$urandom, $urandom},
				{$urandom, $urandom});
		end else if (pick < 38) begin
			wall = wall + $urandom_range(1, 4);
			send_op(itct_pkg::MODE_START, wall, now);
		end else if (pick < 68 && open_stamps.size() != 0) begin
			k = $urandom_range(1) ? oldest_open() : $urandom_range(open_stamps.size() - 1);
			send_op(itct_pkg::MODE_COMMIT, open_stamps[k], now);
		end else if (pick < 74 && open_stamps.size() != 0) begin
			send_op(itct_pkg::MODE_START, open_stamps[$urandom_range(open_stamps.size() - 1)],
				now);
		end else if (pick < 80) begin
			send_op(itct_pkg::MODE_COMMIT, wall - 64'd40 + $urandom_range(0, 60), now);
		end else if (pick < 90) begin
			case ($urandom_range(3))
				0: t = open_stamps.size() != 0 ?
					open_stamps[$urandom_range(open_stamps.size() - 1)] : wall;
				1: t = wall - $urandom_range(0, 30);
				2: t = wall + $urandom_range(0, 3);
				default: t = {$urandom, $urandom};
			endcase
			send_op(itct_pkg::MODE_QRY_ONE, t, now);
		end else begin
			send_op(itct_pkg::MODE_QRY_ALL, wall - 64'd20 + $urandom_range(0, 25), now);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= itct_pkg::MODE_START;
		ts <= '0;
		clock_now <= '0;
		send_idle_pct = 12;
		recv_idle_pct = 51;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: queries on the empty table, absent commit, wrap of the high mark
		send_op(itct_pkg::MODE_QRY_ONE, 64'd0, 64'd0);
		send_op(itct_pkg::MODE_QRY_ALL, TS_MAX, TS_MAX - 64'd1);
		send_op(itct_pkg::MODE_QRY_ALL, 64'd0, 64'd0);
		send_op(itct_pkg::MODE_COMMIT, 64'd7, 64'd0);
		send_op(itct_pkg::MODE_START, TS_MAX, TS_MAX);
		send_op(itct_pkg::MODE_QRY_ONE, TS_MAX, TS_MAX);
		send_op(itct_pkg::MODE_COMMIT, TS_MAX, TS_MAX);
		// fill the table, duplicate on a full table, then a start that does not fit
		for (int i = 10; i < 10 + itct_pkg::SLOTS; i++)
			send_op(itct_pkg::MODE_START, 64'(i), 64'(i));
		send_op(itct_pkg::MODE_START, 64'd10, 64'd30);
		send_op(itct_pkg::MODE_START, 64'd30, 64'd30);
		send_op(itct_pkg::MODE_COMMIT, 64'd10, 64'd30);
		wall = 64'd40;

		// random traffic in three idling phases
		for (int i = 0; i < RANDOM_ITEMS / 3; i++)
			random_op();
		send_idle_pct = 51;
		recv_idle_pct = 12;
		for (int i = 0; i < RANDOM_ITEMS / 3; i++)
			random_op();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); i++)
			random_op();
		in_valid <= 1'b0;

		// drain, then let the last sweep settle
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/itct_pkg.sv
hdl/itct_ram.sv
hdl/inflight_timestamp_commit_tracker.sv
bench/itct_commit_checker.sv
bench/inflight_timestamp_commit_tracker_test.sv
